/* rtl/sha256_pkg.sv */
// SHA-256 core package: constants, types and round functions.
`default_nettype none
package sha256_pkg;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ROUND,
    ST_PAD,
    ST_ROUND_FIN,
    ST_EMIT
  } ctrl_state_t;

  typedef struct packed {
    logic load_byte;
    logic start_block;
    logic round_step;
    logic finish_block;
    logic pad_step;
    logic msg_clear;
  } dp_cmd_t;

  typedef struct packed {
    logic       block_full;
    logic       last_round;
    logic       pad_done;
    logic [6:0] fill;
  } dp_stat_t;

  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [6:0]  LEN_POS  = 7'd56;

  function automatic logic [31:0] init_h(input logic [2:0] idx);
    case (idx)
      3'd0: init_h = 32'h6a09e667;
      3'd1: init_h = 32'hbb67ae85;
      3'd2: init_h = 32'h3c6ef372;
      3'd3: init_h = 32'ha54ff53a;
      3'd4: init_h = 32'h510e527f;
      3'd5: init_h = 32'h9b05688c;
      3'd6: init_h = 32'h1f83d9ab;
      default: init_h = 32'h5be0cd19;
    endcase
  endfunction

  function automatic logic [31:0] round_k(input logic [5:0] idx);
    logic [31:0] k [64];
    k = '{
      32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
      32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
      32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
      32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
      32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
      32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
      32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
      32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
      32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
      32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
      32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};
    round_k = k[idx];
  endfunction

  function automatic logic [31:0] ror32(input logic [31:0] x, input int n);
    ror32 = (x >> n) | (x << (32 - n));
  endfunction

endpackage
`default_nettype wire

/* rtl/sha256_ctrl.sv */
// SHA-256 controller: sequences byte loading, padding, rounds and digest output.
`default_nettype none
module sha256_ctrl (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic                 byte_present,
  input  wire logic                 end_of_message,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [2:0]                word_index,
  output logic                      last_word,
  output sha256_pkg::dp_cmd_t       cmd,
  input  wire sha256_pkg::dp_stat_t stat
);
  import sha256_pkg::*;

  ctrl_state_t state, state_next;
  logic        fin_pending, fin_pending_next;
  logic [2:0]  word_cnt;
  logic        accept, emit_take;

  assign accept    = in_valid && !in_stall;
  assign emit_take = out_valid && !out_stall;
  assign word_index = word_cnt;
  assign last_word  = (word_cnt == 3'd7);

  always_comb begin
    state_next       = state;
    fin_pending_next = fin_pending;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          fin_pending_next = end_of_message;
          if (byte_present && stat.fill == 7'd63) state_next = ST_ROUND;
          else if (end_of_message) state_next = ST_PAD;
        end
      end
      ST_ROUND: begin
        if (stat.last_round) state_next = fin_pending ? ST_PAD : ST_IDLE;
      end
      ST_PAD: begin
        // pad writes one byte a cycle; block_full means a block is ready
        if (stat.block_full) state_next = stat.pad_done ? ST_ROUND_FIN : ST_ROUND;
      end
      ST_ROUND_FIN: begin
        if (stat.last_round) state_next = ST_EMIT;
      end
      ST_EMIT: begin
        if (emit_take && last_word) begin
          state_next       = ST_IDLE;
          fin_pending_next = 1'b0;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd          = '0;
    in_stall     = 1'b1;
    out_valid    = 1'b0;
    case (state)
      ST_IDLE: begin
        in_stall      = 1'b0;
        cmd.load_byte = accept && byte_present;
        cmd.start_block = accept && byte_present && stat.fill == 7'd63;
      end
      ST_ROUND, ST_ROUND_FIN: begin
        cmd.round_step   = 1'b1;
        cmd.finish_block = stat.last_round;
      end
      ST_PAD: begin
        cmd.pad_step    = !stat.block_full;
        cmd.start_block = stat.block_full;
      end
      ST_EMIT: begin
        out_valid     = 1'b1;
        cmd.msg_clear = emit_take && last_word;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ST_IDLE;
      fin_pending <= 1'b0;
      word_cnt    <= 3'd0;
    end else begin
      state       <= state_next;
      fin_pending <= fin_pending_next;
      if (emit_take) word_cnt <= word_cnt + 3'd1;
    end
  end
endmodule
`default_nettype wire

/* rtl/sha256_dpath.sv */
// SHA-256 datapath: block buffer, message schedule, round unit and hash state.
`default_nettype none
module sha256_dpath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [7:0]          data_byte,
  input  wire sha256_pkg::dp_cmd_t cmd,
  output sha256_pkg::dp_stat_t     stat,
  input  wire logic [2:0]          word_index,
  output logic [31:0]              digest_word
);
  import sha256_pkg::*;

  // block is assembled straight into the schedule window, big-endian per word
  logic [31:0] w [16];
  logic [6:0]  fill;
  logic [63:0] message_bits;
  logic        pad_started;
  logic        len_block;
  logic [31:0] hash_words [8];
  logic [31:0] v [8];
  logic [31:0] v_step [8];
  logic [5:0]  round;
  logic        busy;

  logic [7:0]  pad_val;
  logic [7:0]  wr_byte;
  logic [63:0] len_shift;
  logic [31:0] s0, s1, w_new, big0, big1, ch, maj, t1, t2, kw;

  always_comb begin
    stat.fill       = fill;
    stat.block_full = (fill == 7'd64);
    stat.last_round = busy && (round == 6'd63);
    stat.pad_done   = len_block;
  end

  assign digest_word = hash_words[word_index];

  // pad byte: 0x80 first, then zeros, then length bytes from offset 56 of the last block
  always_comb begin
    len_shift = message_bits >> {3'd7 - fill[2:0], 3'b000};
    if (!pad_started) pad_val = PAD_BYTE;
    else if (len_block && fill >= LEN_POS) pad_val = len_shift[7:0];
    else pad_val = 8'h00;
    wr_byte = cmd.load_byte ? data_byte : pad_val;
  end

  always_comb begin
    s0    = ror32(w[1], 7) ^ ror32(w[1], 18) ^ (w[1] >> 3);
    s1    = ror32(w[14], 17) ^ ror32(w[14], 19) ^ (w[14] >> 10);
    w_new = s1 + w[9] + s0 + w[0];
    big1  = ror32(v[4], 6) ^ ror32(v[4], 11) ^ ror32(v[4], 25);
    ch    = (v[4] & v[5]) ^ (~v[4] & v[6]);
    kw    = round_k(round) + w[0];
    t1    = v[7] + big1 + ch + kw;
    big0  = ror32(v[0], 2) ^ ror32(v[0], 13) ^ ror32(v[0], 22);
    maj   = (v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]);
    t2    = big0 + maj;
    v_step[0] = t1 + t2;
    v_step[1] = v[0];
    v_step[2] = v[1];
    v_step[3] = v[2];
    v_step[4] = v[3] + t1;
    v_step[5] = v[4];
    v_step[6] = v[5];
    v_step[7] = v[6];
  end

  always_ff @(posedge clk) begin
    if (cmd.load_byte || cmd.pad_step) begin
      w[fill[5:2]][{~fill[1:0], 3'b000} +: 8] <= wr_byte;
    end else if (cmd.round_step) begin
      for (int i = 0; i < 15; i++) w[i] <= w[i+1];
      w[15] <= w_new;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start_block) begin
      for (int i = 0; i < 8; i++) v[i] <= hash_words[i];
    end else if (cmd.round_step) begin
      for (int i = 0; i < 8; i++) v[i] <= v_step[i];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fill         <= '0;
      message_bits <= '0;
      pad_started  <= 1'b0;
      len_block    <= 1'b0;
      round        <= '0;
      busy         <= 1'b0;
      for (int i = 0; i < 8; i++) hash_words[i] <= init_h(3'(i));
    end else begin
      if (cmd.load_byte || cmd.pad_step) fill <= fill + 7'd1;
      else if (cmd.finish_block) fill <= '0;
      if (cmd.load_byte) message_bits <= message_bits + 64'd8;
      else if (cmd.msg_clear) message_bits <= '0;
      // length goes in this block only if the marker landed below offset 56,
      // otherwise in the block after it
      if (cmd.pad_step && !pad_started) begin
        pad_started <= 1'b1;
        len_block   <= (fill < LEN_POS);
      end else if (cmd.finish_block && pad_started) begin
        len_block <= 1'b1;
      end else if (cmd.msg_clear) begin
        pad_started <= 1'b0;
        len_block   <= 1'b0;
      end
      if (cmd.start_block) begin
        busy  <= 1'b1;
        round <= '0;
      end else if (cmd.round_step) begin
        round <= round + 6'd1;
        if (round == 6'd63) busy <= 1'b0;
      end
      if (cmd.finish_block) begin
        for (int i = 0; i < 8; i++) hash_words[i] <= hash_words[i] + v_step[i];
      end else if (cmd.msg_clear) begin
        for (int i = 0; i < 8; i++) hash_words[i] <= init_h(3'(i));
      end
    end
  end
endmodule
`default_nettype wire

/* rtl/sha256_hash_core.sv */
// SHA-256 hash core top level.
`default_nettype none
// Byte-stream SHA-256. A byte is taken per transaction that carries one while
// the block buffer fills; the transaction that completes a 64-byte block stalls
// the input for the 64 compression rounds (one round a cycle in a single round
// unit). On end_of_message the core writes pad bytes one a cycle, launches each
// padded block, runs one or two more compressions, then presents the eight
// digest words, word 0 first, and restarts from the initial hash values. The
// worst case for the closing transaction is a marker at offset 56: 8 pad bytes,
// a launch, 64 rounds, 64 pad bytes, a launch and 64 rounds come before the
// first digest word, followed by the eight output transactions.
module sha256_hash_core (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic [31:0]      digest_word,
  output logic [2:0]       word_index,
  output logic             last_word
);
  import sha256_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  sha256_ctrl u_ctrl (
    .clk, .rst, .in_valid, .in_stall, .byte_present, .end_of_message,
    .out_valid, .out_stall, .word_index, .last_word, .cmd, .stat
  );

  sha256_dpath u_dpath (
    .clk, .rst, .data_byte, .cmd, .stat, .word_index, .digest_word
  );

`ifndef SYNTHESIS
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(out_valid && !in_stall)) else $error("input open while digest pending");
  a_last_seven: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (last_word == (word_index == 3'd7))) else $error("last flag");
  a_cmd_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.load_byte && cmd.pad_step)) else $error("buffer write clash");
`endif
endmodule
`default_nettype wire

/* tb/sv/sha256_hash_checker.sv */
// Checker for sha256_hash_core: watches both channels, predicts digests, compares.
`timescale 1ns / 100ps
module sha256_hash_checker (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  input  wire logic        in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        byte_present,
  input  wire logic        end_of_message,
  input  wire logic        out_valid,
  input  wire logic        out_stall,
  input  wire logic [31:0] digest_word,
  input  wire logic [2:0]  word_index,
  input  wire logic        last_word,
  output int               fail_count,
  output int               pending_words
);

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        last;
  } digest_beat_t;

  localparam logic [31:0] H_INIT [8] = '{
    32'h6a09e667, 32'hbb67ae85, 32'h3c6ef372, 32'ha54ff53a,
    32'h510e527f, 32'h9b05688c, 32'h1f83d9ab, 32'h5be0cd19};

  localparam logic [31:0] K_TAB [64] = '{
    32'h428a2f98, 32'h71374491, 32'hb5c0fbcf, 32'he9b5dba5, 32'h3956c25b, 32'h59f111f1,
    32'h923f82a4, 32'hab1c5ed5, 32'hd807aa98, 32'h12835b01, 32'h243185be, 32'h550c7dc3,
    32'h72be5d74, 32'h80deb1fe, 32'h9bdc06a7, 32'hc19bf174, 32'he49b69c1, 32'hefbe4786,
    32'h0fc19dc6, 32'h240ca1cc, 32'h2de92c6f, 32'h4a7484aa, 32'h5cb0a9dc, 32'h76f988da,
    32'h983e5152, 32'ha831c66d, 32'hb00327c8, 32'hbf597fc7, 32'hc6e00bf3, 32'hd5a79147,
    32'h06ca6351, 32'h14292967, 32'h27b70a85, 32'h2e1b2138, 32'h4d2c6dfc, 32'h53380d13,
    32'h650a7354, 32'h766a0abb, 32'h81c2c92e, 32'h92722c85, 32'ha2bfe8a1, 32'ha81a664b,
    32'hc24b8b70, 32'hc76c51a3, 32'hd192e819, 32'hd6990624, 32'hf40e3585, 32'h106aa070,
    32'h19a4c116, 32'h1e376c08, 32'h2748774c, 32'h34b0bcb5, 32'h391c0cb3, 32'h4ed8aa4a,
    32'h5b9cca4f, 32'h682e6ff3, 32'h748f82ee, 32'h78a5636f, 32'h84c87814, 32'h8cc70208,
    32'h90befffa, 32'ha4506ceb, 32'hbef9a3f7, 32'hc67178f2};

  logic [31:0]  hash_h [8];
  logic [7:0]   blk [64];
  int unsigned  fill;
  logic [63:0]  msg_bits;
  digest_beat_t digest_q [$];

  function automatic logic [31:0] rotr(input logic [31:0] x, input int n);
    return (x >> n) | (x << (32 - n));
  endfunction

  task automatic compress();
    logic [31:0] w [64];
    logic [31:0] v [8];
    logic [31:0] t1, t2;
    for (int i = 0; i < 16; i++)
      w[i] = {blk[4*i], blk[4*i+1], blk[4*i+2], blk[4*i+3]};
    for (int i = 16; i < 64; i++)
      w[i] = (rotr(w[i-2], 17) ^ rotr(w[i-2], 19) ^ (w[i-2] >> 10)) + w[i-7]
           + (rotr(w[i-15], 7) ^ rotr(w[i-15], 18) ^ (w[i-15] >> 3)) + w[i-16];
    v = hash_h;
    for (int i = 0; i < 64; i++) begin
      t1 = v[7] + (rotr(v[4], 6) ^ rotr(v[4], 11) ^ rotr(v[4], 25))
         + ((v[4] & v[5]) ^ (~v[4] & v[6])) + K_TAB[i] + w[i];
      t2 = (rotr(v[0], 2) ^ rotr(v[0], 13) ^ rotr(v[0], 22))
         + ((v[0] & v[1]) ^ (v[0] & v[2]) ^ (v[1] & v[2]));
      v[7] = v[6]; v[6] = v[5]; v[5] = v[4]; v[4] = v[3] + t1;
      v[3] = v[2]; v[2] = v[1]; v[1] = v[0]; v[0] = t1 + t2;
    end
    for (int i = 0; i < 8; i++) hash_h[i] += v[i];
  endtask

  task automatic restart_message();
    hash_h = H_INIT;
    fill = 0;
    msg_bits = '0;
  endtask

  task automatic absorb_transaction(input logic [7:0] b, input logic present,
                                    input logic fin);
    digest_beat_t beat;
    if (present) begin
      blk[fill] = b;
      fill++;
      msg_bits += 64'd8;
      if (fill == 64) begin
        compress();
        fill = 0;
      end
    end
    if (fin) begin
      blk[fill] = 8'h80;
      fill++;
      if (fill > 56) begin
        while (fill < 64) blk[fill++] = 8'h00;
        compress();
        fill = 0;
      end
      while (fill < 56) blk[fill++] = 8'h00;
      for (int i = 0; i < 8; i++) blk[56+i] = msg_bits[63-8*i -: 8];
      compress();
      for (int i = 0; i < 8; i++) begin
        beat.word = hash_h[i];
        beat.idx  = 3'(i);
        beat.last = (i == 7);
        digest_q  = {digest_q, beat};
      end
      restart_message();
    end
  endtask

  task automatic report(input string what, input logic [31:0] got, input logic [31:0] exp);
    $display("%0t mismatch %s: got %h expected %h", $realtime, what, got, exp);
    fail_count++;
  endtask

  always @(posedge clk) begin
    digest_beat_t exp_beat;
    if (rst) begin
      restart_message();
      digest_q.delete();
      fail_count = 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (digest_q.size() == 0) begin
          report("unexpected digest word", digest_word, 32'h0);
        end else begin
          exp_beat = digest_q.pop_front();
          if (digest_word !== exp_beat.word) report("digest_word", digest_word, exp_beat.word);
          if (word_index !== exp_beat.idx) report("word_index", 32'(word_index), 32'(exp_beat.idx));
          if (last_word !== exp_beat.last) report("last_word", 32'(last_word), 32'(exp_beat.last));
        end
      end
      if (in_valid && !in_stall)
        absorb_transaction(data_byte, byte_present, end_of_message);
    end
    pending_words = digest_q.size();
  end

endmodule

/* tb/sv/sha256_hash_core_tb.sv */
// Testbench top for sha256_hash_core: stimulus, idling and final verdict.
`timescale 1ns / 100ps
module sha256_hash_core_tb;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = '0;
  logic        byte_present = 1'b0;
  logic        end_of_message = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b1;
  logic [31:0] digest_word;
  logic [2:0]  word_index;
  logic        last_word;
  int          fail_count;
  int          pending_words;
  bit          drain_idle = 1'b0;
  int          items_sent = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  sha256_hash_core u_dut (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .byte_present, .end_of_message,
    .out_valid, .out_stall, .digest_word, .word_index, .last_word
  );

  sha256_hash_checker u_chk (
    .clk, .rst, .in_valid, .in_stall, .data_byte, .byte_present, .end_of_message,
    .out_valid, .out_stall, .digest_word, .word_index, .last_word,
    .fail_count, .pending_words
  );

  // busy mode draws 0 for a back-to-back stretch, otherwise a random gap length
  function automatic int draw_gap(input bit busy_mode);
    if (busy_mode) return 0;
    return $urandom_range(0, 17);
  endfunction

  // valid stays high across back-to-back items; dropped only for a gap
  task automatic send_item(input logic [7:0] b, input logic present, input logic fin,
                           input int gap);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid       <= 1'b1;
    data_byte      <= b;
    byte_present   <= present;
    end_of_message <= fin;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    items_sent++;
  endtask

  // message of given length with random bytes; noise items sprinkled in
  task automatic send_message(input int len, input bit busy_mode, input bit end_alone);
    int noise;
    for (int i = 0; i < len; i++) begin
      noise = $urandom_range(0, 15);
      if (noise == 0) send_item(8'($urandom), 1'b0, 1'b0, draw_gap(busy_mode));
      send_item(8'($urandom), 1'b1, (!end_alone && i == len - 1),
                busy_mode ? 0 : $urandom_range(0, 3) == 0 ? draw_gap(0) : 0);
    end
    if (end_alone || len == 0) send_item(8'($urandom), 1'b0, 1'b1, draw_gap(busy_mode));
  endtask

  // receiver stall: per transaction draw a wait, with stall-free stretches
  initial begin
    int wait_cycles;
    @(negedge clk);
    while (1) begin
      wait_cycles = ($urandom_range(0, 3) == 0 || drain_idle) ? 0 : $urandom_range(0, 17);
      if (wait_cycles > 0) begin
        out_stall <= 1'b1;
        repeat (wait_cycles) @(negedge clk);
      end
      out_stall <= 1'b0;
      @(posedge clk);
      while (!out_valid) @(posedge clk);
      @(negedge clk);
    end
  end

  initial begin
    int len;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // directed: empty message, "abc", extreme bytes, boundary lengths
    send_item(8'h00, 1'b0, 1'b1, 0);
    send_item(8'h61, 1'b1, 1'b0, 0);
    send_item(8'h62, 1'b1, 1'b0, 2);
    send_item(8'h63, 1'b1, 1'b1, 0);
    send_item(8'hff, 1'b0, 1'b0, 1);
    send_item(8'hff, 1'b1, 1'b0, 0);
    send_item(8'h00, 1'b1, 1'b0, 0);
    send_item(8'h55, 1'b1, 1'b0, 0);
    send_item(8'haa, 1'b0, 1'b1, 0);
    send_message(55, 1'b1, 1'b0);
    send_message(56, 1'b0, 1'b0);
    send_message(63, 1'b1, 1'b1);
    send_message(64, 1'b0, 1'b0);
    send_message(64, 1'b1, 1'b1);

    // random messages, lengths mostly short, some across block borders
    while (items_sent < 420) begin
      case ($urandom_range(0, 4))
        0: len = $urandom_range(0, 8);
        1: len = $urandom_range(50, 70);
        2: len = $urandom_range(110, 130);
        default: len = $urandom_range(1, 40);
      endcase
      send_message(len, $urandom_range(0, 2) == 0, $urandom_range(0, 3) == 0);
    end
    in_valid <= 1'b0;

    drain_idle = 1'b1;
    while (pending_words != 0) @(posedge clk);
    repeat (300) @(posedge clk);
    if (fail_count == 0) begin
      $display("** sha256_hash_core: PASSED **");
    end else begin
      $display("** sha256_hash_core: FAILED **");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("** sha256_hash_core: FAILED **");
    $finish;
  end

endmodule
